// File: rtl/core/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the decimal text formatter.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication.
`define SIDA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SIDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sida_pkg.sv
`default_nettype none

package sida_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned ShiftCntW  = $clog2(ValueWidth);

  localparam logic [ByteWidth-1:0] CharMinus = 8'h2D;
  localparam logic [ByteWidth-1:0] CharPlus  = 8'h2B;
  localparam logic [ByteWidth-1:0] CharZero  = 8'h30;
  localparam logic [ByteWidth-1:0] CharEnd   = 8'h5E;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigit,
    StTerm
  } state_e;

  typedef enum logic [1:0] {
    SelSign,
    SelDigit,
    SelTerm
  } sel_e;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic load;
    logic shift;
    logic dec_idx;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic shift_last;
    logic digit_zero;
    logic idx_zero;
  } sts_t;

  // Double-dabble correction: add 3 to a BCD digit of 5 or more before the shift.
  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? (d + 4'd3) : d;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sida_in_if.sv
`default_nettype none

interface sida_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sida_pkg::ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sida_out_if.sv
`default_nettype none

interface sida_out_if;
  logic                          valid;
  logic                          ready;
  logic [sida_pkg::ByteWidth-1:0] text_byte;
  logic                          last;

  modport source (output valid, output text_byte, output last, input ready);
  modport sink   (input valid, input text_byte, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/signed_int_to_decimal_ascii.sv
// Formats one signed 32-bit request as ASCII text: a sign byte ('-' or '+', '+' for
// zero), the decimal digits without leading zeros, then '^' flagged by last. A request
// is taken only while the block is idle. The binary-to-BCD unit shifts one bit per
// cycle: a load in the accepting cycle, then 32 shifts. The digit scan then steps down
// past each leading zero digit (0 to 9 of them) and settles on the first printed digit,
// and the 3 to 12 output bytes follow at one per cycle while the sink is ready. Skipped
// and printed digits always add up to ten. The next request is taken only after the
// terminator has been sent, and the sink holding ready low during output delays it.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sida_in_if.sink   in_i,
  sida_out_if.source out_o
);
  import sida_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sida_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .value_i     (in_i.value),
    .sts_o       (sts),
    .text_byte_o (out_o.text_byte),
    .last_o      (out_o.last)
  );

  assign in_i.ready  = cmd.in_ready;
  assign out_o.valid = cmd.out_valid;

`include "signed_int_to_decimal_ascii_assert.svh"

  `SIDA_ASSERT_SAME(a_no_overlap, in_i.valid && in_i.ready, !out_o.valid,
                    "request accepted while output pending")
  `SIDA_ASSERT_NEXT(a_busy_after_req, in_i.valid && in_i.ready, !in_i.ready && !out_o.valid,
                    "not busy after request")
  `SIDA_ASSERT_SAME(a_last_is_term, out_o.valid && out_o.last, out_o.text_byte == CharEnd,
                    "last flag without terminator")
  `SIDA_ASSERT_NEXT(a_idle_after_last, out_o.valid && out_o.ready && out_o.last, in_i.ready,
                    "not idle after terminator")

endmodule

`default_nettype wire

// File: rtl/core/sida_datapath.sv
`default_nettype none

module sida_datapath (
  input  wire logic                                   clk_i,
  input  wire sida_pkg::cmd_t                         cmd_i,
  input  wire logic signed [sida_pkg::ValueWidth-1:0] value_i,
  output sida_pkg::sts_t                              sts_o,
  output logic [sida_pkg::ByteWidth-1:0]              text_byte_o,
  output logic                                        last_o
);
  import sida_pkg::*;

  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [3:0]            bcd_q [NumDigits];
  logic [3:0]            bcd_d [NumDigits];
  logic [DigitIdxW-1:0]  idx_q, idx_d;
  logic [ShiftCntW-1:0]  cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic [ValueWidth-1:0] raw;
  logic [3:0]            adj [NumDigits];
  logic [3:0]            cur_digit;

  assign raw = value_i;

  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    for (int i = 0; i < NumDigits; i++) begin
      adj[i]   = bcd_adjust(bcd_q[i]);
      bcd_d[i] = bcd_q[i];
    end
    if (cmd_i.load) begin
      neg_d = raw[ValueWidth-1];
      // Two's complement negation; the most negative value maps onto itself as unsigned.
      mag_d = raw[ValueWidth-1] ? (~raw + ValueWidth'(1)) : raw;
      idx_d = DigitIdxW'(NumDigits - 1);
      cnt_d = '0;
      for (int i = 0; i < NumDigits; i++) begin
        bcd_d[i] = '0;
      end
    end else if (cmd_i.shift) begin
      mag_d = {mag_q[ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q + ShiftCntW'(1);
      bcd_d[0] = {adj[0][2:0], mag_q[ValueWidth-1]};
      for (int i = 1; i < NumDigits; i++) begin
        bcd_d[i] = {adj[i][2:0], adj[i-1][3]};
      end
    end else if (cmd_i.dec_idx) begin
      idx_d = idx_q - DigitIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    for (int i = 0; i < NumDigits; i++) begin
      bcd_q[i] <= bcd_d[i];
    end
  end

  assign cur_digit = bcd_q[idx_q];

  assign sts_o.shift_last = (cnt_q == ShiftCntW'(ValueWidth - 1));
  assign sts_o.digit_zero = (cur_digit == 4'd0);
  assign sts_o.idx_zero   = (idx_q == '0);

  always_comb begin
    unique case (cmd_i.sel)
      SelSign:  text_byte_o = neg_q ? CharMinus : CharPlus;
      SelDigit: text_byte_o = CharZero + {4'd0, cur_digit};
      SelTerm:  text_byte_o = CharEnd;
      default:  text_byte_o = CharEnd;
    endcase
  end

  assign last_o = (cmd_i.sel == SelTerm);

endmodule

`default_nettype wire

// File: rtl/core/sida_ctrl.sv
`default_nettype none

module sida_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           out_ready_i,
  input  wire sida_pkg::sts_t sts_i,
  output sida_pkg::cmd_t      cmd_o
);
  import sida_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StConv;
      StConv:  if (sts_i.shift_last) state_d = StSkip;
      // Walk down past leading zeros; the units digit is always printed.
      StSkip:  if (!sts_i.digit_zero || sts_i.idx_zero) state_d = StSign;
      StSign:  if (out_ready_i) state_d = StDigit;
      StDigit: if (out_ready_i && sts_i.idx_zero) state_d = StTerm;
      StTerm:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '{in_ready: 1'b0, out_valid: 1'b0, load: 1'b0, shift: 1'b0,
              dec_idx: 1'b0, sel: SelSign};
    unique case (state_q)
      StIdle: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = in_valid_i;
      end
      StConv: begin
        cmd_o.shift = 1'b1;
      end
      StSkip: begin
        cmd_o.dec_idx = sts_i.digit_zero && !sts_i.idx_zero;
      end
      StSign: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SelSign;
      end
      StDigit: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SelDigit;
        cmd_o.dec_idx   = out_ready_i && !sts_i.idx_zero;
      end
      StTerm: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SelTerm;
      end
      default: begin
        cmd_o.in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
